// ===== src/afce_pkg.sv =====
`default_nettype none

package afce_pkg;

    localparam int FRAME_MAX = 32;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int ADDR_W    = $clog2(FRAME_MAX);
    localparam int NUM_W     = 14;

    localparam logic [7:0] CH_START = 8'h53;
    localparam logic [7:0] CH_END   = 8'h44;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(15);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FRAME_MAX);
    localparam logic [CNT_W-1:0] POS_ID    = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_LEN   = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_DAT   = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_CKS   = CNT_W'(10);
    localparam logic [CNT_W-1:0] POS_END   = CNT_W'(14);

    typedef struct packed {
        logic start;
        logic store;
        logic rd;
        logic ld;
    } dp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_end;
        logic full;
        logic ok;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/afce_ctrl.sv =====
`default_nettype none

module afce_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire afce_pkg::dp_stat_t stat,
    output afce_pkg::dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RECV = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LD   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_RECV);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && stat.is_start)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RECV;
                end
            end
            ST_RECV:
            begin
                if (acc)
                begin
                    if (stat.is_start)
                    begin
                        cmd.start = 1'b1;
                    end
                    else if (stat.full)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (stat.is_end)
                        begin
                            state_next = stat.ok ? ST_RD : ST_IDLE;
                        end
                    end
                end
            end
            ST_RD:
            begin
                if (stat.out_free)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_LD;
                end
            end
            ST_LD:
            begin
                cmd.ld     = 1'b1;
                state_next = stat.rd_last ? ST_IDLE : ST_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/afce_dp.sv =====
`default_nettype none

module afce_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire afce_pkg::dp_cmd_t cmd,
    output afce_pkg::dp_stat_t     stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             tx_byte,
    output logic                   last_byte
);

    logic [7:0]                   mem [afce_pkg::FRAME_MAX];
    logic [afce_pkg::CNT_W-1:0]   count_reg;
    logic [afce_pkg::CNT_W-1:0]   count_next;
    logic [afce_pkg::CNT_W-1:0]   count_inc;
    logic [afce_pkg::ADDR_W-1:0]  ptr_reg;
    logic [afce_pkg::ADDR_W-1:0]  wr_addr;
    logic [7:0]                   sum_reg;
    logic [7:0]                   sum_next;
    logic [afce_pkg::NUM_W-1:0]   num_reg;
    logic [afce_pkg::NUM_W-1:0]   num_next;
    logic                         lead_reg;
    logic                         lead_next;
    logic                         stop_reg;
    logic                         stop_next;
    logic [7:0]                   rd_data_reg;
    logic                         rd_last_reg;
    logic                         out_valid_reg;
    logic [7:0]                   tx_reg;
    logic                         last_reg;

    logic in_sum;
    logic in_cks;
    logic first;
    logic lead_eff;
    logic skip;
    logic digit;

    assign count_inc = count_reg + afce_pkg::CNT_W'(1);
    assign wr_addr   = cmd.start ? '0 : count_reg[afce_pkg::ADDR_W-1:0];

    assign in_sum = (count_reg >= afce_pkg::POS_ID) && (count_reg < afce_pkg::POS_CKS);
    assign in_cks = (count_reg >= afce_pkg::POS_CKS) && (count_reg < afce_pkg::POS_END);
    assign first  = (count_reg == afce_pkg::POS_ID) || (count_reg == afce_pkg::POS_LEN)
                 || (count_reg == afce_pkg::POS_DAT) || (count_reg == afce_pkg::POS_CKS);
    assign lead_eff = first || lead_reg;
    assign skip     = lead_eff && (rx_byte == afce_pkg::CH_ZERO);
    assign digit    = (rx_byte >= afce_pkg::CH_ZERO) && (rx_byte <= afce_pkg::CH_NINE);

    // field parse runs as bytes land; all fields complete before any valid end
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        num_next   = num_reg;
        lead_next  = lead_reg;
        stop_next  = stop_reg;
        if (cmd.start)
        begin
            count_next = afce_pkg::CNT_W'(1);
            sum_next   = '0;
            num_next   = '0;
            lead_next  = 1'b1;
            stop_next  = 1'b0;
        end
        else if (cmd.store)
        begin
            count_next = count_inc;
            if (in_sum)
            begin
                lead_next = skip;
                if (!skip)
                begin
                    sum_next = sum_reg + rx_byte;
                end
            end
            else if (in_cks)
            begin
                lead_next = skip;
                if (!skip)
                begin
                    if (!stop_reg && digit)
                    begin
                        num_next = afce_pkg::NUM_W'(num_reg * afce_pkg::NUM_W'(10))
                                 + afce_pkg::NUM_W'(rx_byte - afce_pkg::CH_ZERO);
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        stat.is_start = (rx_byte == afce_pkg::CH_START);
        stat.is_end   = (rx_byte == afce_pkg::CH_END);
        stat.full     = (count_reg >= afce_pkg::FULL_CNT);
        stat.ok       = (count_inc >= afce_pkg::MIN_FRAME)
                     && (num_reg == afce_pkg::NUM_W'(sum_reg));
        stat.rd_last  = rd_last_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.store)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            num_reg       <= '0;
            lead_reg      <= 1'b1;
            stop_reg      <= 1'b0;
            ptr_reg       <= '0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            num_reg   <= num_next;
            lead_reg  <= lead_next;
            stop_reg  <= stop_next;
            if (cmd.start)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.rd)
            begin
                ptr_reg     <= ptr_reg + afce_pkg::ADDR_W'(1);
                rd_last_reg <= ({1'b0, ptr_reg} + afce_pkg::CNT_W'(1)) == count_reg;
            end
            if (cmd.ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld)
        begin
            tx_reg   <= rd_data_reg;
            last_reg <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_reg;
    assign last_byte = last_reg;

endmodule

`default_nettype wire

// ===== src/ascii_frame_checksum_echo_top.sv =====
`default_nettype none

// channel | handshake            | payload
// in      | in_valid / in_ready   | rx_byte
// out     | out_valid / out_ready | tx_byte, last_byte
//
// Receive: one byte a cycle; checksum fields are parsed as each beat lands.
// Echo: each byte is a store read, then an output register load, before the next
// byte is read; input is held off while the frame is read out.
// Reset clears the frame controller and output valid; the frame store is not cleared.
// Downstream stall holds the output register and pauses the echo read sequence.

module ascii_frame_checksum_echo_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      tx_byte,
    output logic            last_byte
);

    afce_pkg::dp_cmd_t  cmd;
    afce_pkg::dp_stat_t stat;

    afce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    afce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 2 * afce_pkg::FRAME_MAX + 16;
    localparam int RANDOM_BEATS  = 150;
    localparam int PRINT_LIMIT   = 100;

    typedef logic [7:0] frame_t [afce_pkg::FRAME_MAX];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } echo_t;

    typedef enum {CK_PADDED, CK_ENDED, CK_WRONG, CK_OVER} cks_style_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    // frame predictor
    frame_t      rx_buf;
    int unsigned rx_count  = 0;
    bit          receiving = 1'b0;
    echo_t       echo_q [$];
    echo_t       echo_head;

    frame_t      frm;
    int unsigned burst_left   = 0;
    bit          steady       = 1'b0;
    logic [15:0] stall_pat    = '0;
    logic [3:0]  stall_pos    = '0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count   = 0;

    ascii_frame_checksum_echo_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sum of one header field, leading '0' characters skipped
    function automatic logic [7:0] field_total(frame_t f, int unsigned pos, int unsigned len);
        logic [7:0]  acc;
        int unsigned k;
        acc = '0;
        k   = 0;
        while (k < len && f[pos + k] == afce_pkg::CH_ZERO)
            k++;
        for (; k < len; k++)
            acc += f[pos + k];
        return acc;
    endfunction

    function automatic logic [7:0] head_sum(frame_t f);
        return field_total(f, afce_pkg::POS_ID, 4) + field_total(f, afce_pkg::POS_LEN, 2)
             + field_total(f, afce_pkg::POS_DAT, 3);
    endfunction

    function automatic int unsigned cks_value(frame_t f);
        int unsigned v;
        int unsigned k;
        v = 0;
        k = 0;
        while (k < 4 && f[afce_pkg::POS_CKS + k] == afce_pkg::CH_ZERO)
            k++;
        for (; k < 4 && f[afce_pkg::POS_CKS + k] >= afce_pkg::CH_ZERO
               && f[afce_pkg::POS_CKS + k] <= afce_pkg::CH_NINE; k++)
            v = v * 10 + (f[afce_pkg::POS_CKS + k] - afce_pkg::CH_ZERO);
        return v;
    endfunction

    function automatic void predict_beat(logic [7:0] b);
        int unsigned k;
        echo_t       e;
        if (b == afce_pkg::CH_START)
        begin
            rx_buf[0] = b;
            rx_count  = 1;
            receiving = 1'b1;
        end
        else if (receiving)
        begin
            if (rx_count >= afce_pkg::FRAME_MAX)
            begin
                rx_count  = 0;
                receiving = 1'b0;
            end
            else
            begin
                rx_buf[rx_count] = b;
                rx_count++;
                if (b == afce_pkg::CH_END)
                begin
                    if (rx_count >= afce_pkg::MIN_FRAME
                        && cks_value(rx_buf) == 32'(head_sum(rx_buf)))
                    begin
                        for (k = 0; k < rx_count; k++)
                        begin
                            e.data = rx_buf[k];
                            e.last = (k + 1 == rx_count);
                            echo_q.push_back(e);
                        end
                    end
                    rx_count  = 0;
                    receiving = 1'b0;
                end
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] %s: got %02h, expected %02h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            predict_beat(rx_byte);
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (echo_q.size() == 0)
                report_mismatch("unexpected beat", tx_byte, 8'hxx);
            else
            begin
                echo_head = echo_q.pop_front();
                if (tx_byte !== echo_head.data)
                    report_mismatch("tx_byte", tx_byte, echo_head.data);
                if (last_byte !== echo_head.last)
                    report_mismatch("last_byte", 8'(last_byte), 8'(echo_head.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls on a rolling 16-bit pattern unless steady is set
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = 16'hffff;
                    1:       stall_pat = 16'($urandom) | 16'h0001;
                    2:       stall_pat = 16'h8001;
                    default: stall_pat = 16'($urandom | $urandom);
                endcase
            end
            out_ready <= steady || stall_pat[stall_pos];
            stall_pos = stall_pos + 4'd1;
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == afce_pkg::CH_START || b == afce_pkg::CH_END);
        return b;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = plain_byte();
        while (b >= afce_pkg::CH_ZERO && b <= afce_pkg::CH_NINE);
        return b;
    endfunction

    function automatic logic [7:0] field_byte();
        case ($urandom_range(0, 3))
            0:       return afce_pkg::CH_ZERO;
            1:       return afce_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            default: return plain_byte();
        endcase
    endfunction

    function automatic void put_text(int unsigned pos, string s);
        int unsigned k;
        for (k = 0; k < s.len(); k++)
            frm[pos + k] = s[k];
    endfunction

    // padded: leading '0's to four digits; otherwise the digits end on a non-digit unless they fill all four
    function automatic void put_number(int unsigned val, bit padded);
        string       digits;
        int unsigned lead;
        int unsigned k;
        digits = $sformatf("%0d", val);
        if (padded || digits.len() == 4)
            lead = 4 - digits.len();
        else
            lead = $urandom_range(0, 3 - digits.len());
        for (k = 0; k < 4; k++)
        begin
            if (k < lead)
                frm[afce_pkg::POS_CKS + k] = afce_pkg::CH_ZERO;
            else if (k < lead + digits.len())
                frm[afce_pkg::POS_CKS + k] = digits[k - lead];
            else if (k == lead + digits.len())
                frm[afce_pkg::POS_CKS + k] = non_digit();
            else
                frm[afce_pkg::POS_CKS + k] = plain_byte();
        end
    endfunction

    function automatic void fill_head(logic [7:0] v);
        int unsigned k;
        frm[0] = afce_pkg::CH_START;
        for (k = 1; k < afce_pkg::POS_END; k++)
            frm[k] = v;
        frm[afce_pkg::POS_END] = afce_pkg::CH_END;
    endfunction

    // total above FRAME_MAX leaves the store full with no end marker
    function automatic void build_frame(int unsigned total, cks_style_t style);
        logic [7:0]  sum;
        int unsigned k;
        frm[0] = afce_pkg::CH_START;
        for (k = 1; k < afce_pkg::POS_CKS; k++)
            frm[k] = field_byte();
        sum = head_sum(frm);
        case (style)
            CK_PADDED: put_number(sum, 1'b1);
            CK_ENDED:  put_number(sum, 1'b0);
            CK_WRONG:  put_number(8'(sum + 8'($urandom_range(1, 255))), $urandom_range(0, 1) != 0);
            default:   put_number(sum + 256 * $urandom_range(1, (9999 - sum) / 256), 1'b1);
        endcase
        for (k = afce_pkg::POS_END; k < afce_pkg::FRAME_MAX; k++)
            frm[k] = plain_byte();
        if (total <= afce_pkg::FRAME_MAX)
            frm[total - 1] = afce_pkg::CH_END;
    endfunction

    task automatic send_beat(logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_frm(int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            send_beat(frm[k]);
    endtask

    // hold off the sender until every echo beat is home
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (echo_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic test_idle_bytes();
        send_beat(8'h00);
        send_beat(8'hff);
        send_beat(afce_pkg::CH_END);
        send_beat(afce_pkg::CH_ZERO);
        wait_drain();
    endtask

    task automatic test_frame_lengths();
        build_frame(afce_pkg::MIN_FRAME, CK_PADDED);
        send_frm(afce_pkg::MIN_FRAME);
        steady = 1'b1;
        build_frame(afce_pkg::FRAME_MAX, CK_ENDED);
        send_frm(afce_pkg::FRAME_MAX);
        steady = 1'b0;
        build_frame(afce_pkg::MIN_FRAME - 1, CK_PADDED);
        send_frm(afce_pkg::MIN_FRAME - 1);
        build_frame(2, CK_PADDED);
        send_frm(2);
        wait_drain();
    endtask

    task automatic test_checksum_forms();
        // every field strips to nothing: sum and checksum both zero
        put_text(0, "S0000000000000D");
        send_frm(afce_pkg::MIN_FRAME);
        // top-bit bytes sum as unsigned
        fill_head(8'hff);
        put_number(head_sum(frm), 1'b1);
        send_frm(afce_pkg::MIN_FRAME);
        // sum wraps to zero; a field with no digits reads zero
        fill_head(afce_pkg::CH_ZERO);
        frm[afce_pkg::POS_DAT]     = 8'h80;
        frm[afce_pkg::POS_DAT + 1] = 8'h80;
        frm[afce_pkg::POS_DAT + 2] = 8'h00;
        put_text(afce_pkg::POS_CKS, "z999");
        send_frm(afce_pkg::MIN_FRAME);
        // same sum claimed as 256: above a byte, never matches
        put_text(afce_pkg::POS_CKS, "0256");
        send_frm(afce_pkg::MIN_FRAME);
        // nine '1's sum to 185; digits closed by a zero byte
        fill_head(8'h31);
        put_text(afce_pkg::POS_CKS, "185");
        frm[afce_pkg::POS_CKS + 3] = 8'h00;
        send_frm(afce_pkg::MIN_FRAME);
        // zero byte ahead of the digits ends the number at once
        frm[afce_pkg::POS_CKS] = 8'h00;
        put_text(afce_pkg::POS_CKS + 1, "185");
        send_frm(afce_pkg::MIN_FRAME);
        build_frame(afce_pkg::MIN_FRAME, CK_WRONG);
        send_frm(afce_pkg::MIN_FRAME);
        build_frame(afce_pkg::MIN_FRAME + 2, CK_OVER);
        send_frm(afce_pkg::MIN_FRAME + 2);
        build_frame(afce_pkg::MIN_FRAME, CK_ENDED);
        send_frm(afce_pkg::MIN_FRAME);
        wait_drain();
    endtask

    task automatic test_overflow();
        build_frame(afce_pkg::FRAME_MAX + 1, CK_PADDED);
        send_frm(afce_pkg::FRAME_MAX);
        send_beat(afce_pkg::CH_END);
        send_beat(afce_pkg::CH_END);
        build_frame(afce_pkg::MIN_FRAME, CK_PADDED);
        send_frm(afce_pkg::MIN_FRAME);
        wait_drain();
    endtask

    task automatic test_restart();
        build_frame(afce_pkg::MIN_FRAME, CK_PADDED);
        send_frm(9);
        build_frame(afce_pkg::MIN_FRAME + 1, CK_PADDED);
        send_frm(afce_pkg::MIN_FRAME + 1);
        build_frame(20, CK_PADDED);
        send_frm(afce_pkg::MIN_FRAME);
        build_frame(afce_pkg::MIN_FRAME, CK_ENDED);
        send_frm(afce_pkg::MIN_FRAME);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned roll;
        int unsigned total;
        int unsigned k;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            roll   = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                total = $urandom_range(afce_pkg::MIN_FRAME, afce_pkg::FRAME_MAX);
            else
                total = $urandom_range(afce_pkg::MIN_FRAME, afce_pkg::MIN_FRAME + 3);
            if (roll < 55)
            begin
                build_frame(total, (roll % 2 != 0) ? CK_PADDED : CK_ENDED);
                send_frm(total);
                sent += total;
            end
            else if (roll < 68)
            begin
                build_frame(total, CK_WRONG);
                send_frm(total);
                sent += total;
            end
            else if (roll < 73)
            begin
                build_frame(total, CK_OVER);
                send_frm(total);
                sent += total;
            end
            else if (roll < 80)
            begin
                total = $urandom_range(2, afce_pkg::MIN_FRAME - 1);
                build_frame(total, CK_PADDED);
                send_frm(total);
                sent += total;
            end
            else if (roll < 86)
            begin
                build_frame(afce_pkg::FRAME_MAX + 1, CK_PADDED);
                send_frm(afce_pkg::FRAME_MAX);
                case ($urandom_range(0, 2))
                    0:       send_beat(afce_pkg::CH_END);
                    1:       send_beat(plain_byte());
                    default: send_beat(afce_pkg::CH_START);
                endcase
                sent += afce_pkg::FRAME_MAX + 1;
            end
            else if (roll < 93)
            begin
                build_frame(total, CK_PADDED);
                k = $urandom_range(1, total - 1);
                send_frm(k);
                sent += k;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_beat(8'($urandom));
                sent += k;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drain();
        end
        steady = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_frame_lengths();
        test_checksum_forms();
        test_overflow();
        test_restart();
        test_random_traffic();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/afce_pkg.sv
src/afce_ctrl.sv
src/afce_dp.sv
src/ascii_frame_checksum_echo_top.sv
bench/testbench.sv
